// File: hw/rtl/hee_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hee_pkg
// Types, character codes and helpers shared by the HTML entity escaper.
// ----------------------------------------------------------------------------
package hee_pkg;

	localparam int QueueDepth = 4;
	localparam int MaxRun     = 6;
	localparam int RunW       = 3;

	// character codes
	localparam logic [7:0] CH_AMP   = 8'd38;
	localparam logic [7:0] CH_LT    = 8'd60;
	localparam logic [7:0] CH_GT    = 8'd62;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_QUOTE = 8'd34;
	localparam logic [7:0] CH_APOS  = 8'd39;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_SEMI  = 8'd59;
	localparam logic [7:0] CH_BSLSH = 8'd92;
	localparam logic [7:0] CH_DEL   = 8'd127;
	localparam logic [7:0] CH_HASH  = 8'd35;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_A     = 8'd97;
	localparam logic [7:0] CH_B     = 8'd98;
	localparam logic [7:0] CH_G     = 8'd103;
	localparam logic [7:0] CH_L     = 8'd108;
	localparam logic [7:0] CH_M     = 8'd109;
	localparam logic [7:0] CH_N     = 8'd110;
	localparam logic [7:0] CH_P     = 8'd112;
	localparam logic [7:0] CH_S     = 8'd115;
	localparam logic [7:0] CH_T     = 8'd116;
	localparam logic [7:0] CTRL_MAX = 8'd31;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_end;
	} hee_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_last;
	} hee_out_t;

	// one classified request: the bytes to send, how many, and end of string
	typedef struct packed {
		logic [MaxRun-1:0][7:0] chars;
		logic [RunW-1:0]        len;
		logic                   str_end;
	} hee_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} hee_qstat_t;

	// ASCII decimal digits {hundreds, tens, ones} of an 8-bit value
	function automatic logic [23:0] hee_dec3(input logic [7:0] v);
		logic [1:0]  h;
		logic [7:0]  r;
		logic [15:0] p;
		logic [3:0]  t;
		logic [7:0]  o;
		h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
		r = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
		// r < 100, so r*205 >> 11 is exactly r/10
		p = 16'(r) * 16'd205;
		t = p[14:11];
		o = r - {1'b0, t, 3'b000} - {3'b000, t, 1'b0};
		return {CH_ZERO + {6'd0, h}, CH_ZERO + {4'd0, t}, CH_ZERO + {4'd0, o[3:0]}};
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/hee_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hee_front
// Holds the high-byte mode bit and turns each input byte into a run entry.
// ----------------------------------------------------------------------------
module hee_front
	import hee_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire hee_in_t    req,
	output hee_entry_t      entry
);

	logic       esc_high_q;
	logic [7:0] b;
	logic [23:0] dig;
	logic       num2;
	logic       num3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_high_q <= 1'b0;
		end else if (cfg_we) begin
			esc_high_q <= cfg_wdata;
		end
	end

	assign b   = req.in_byte;
	assign dig = hee_dec3(b);

	// quote and apostrophe have two-digit codes, so they share the numeric form
	assign num2 = (b <= CTRL_MAX) || (b == CH_QUOTE) || (b == CH_APOS) ||
	              (b == CH_SLASH) || (b == CH_SEMI) || (b == CH_BSLSH);
	assign num3 = (b == CH_DEL) || (b[7] && esc_high_q);

	always_comb begin
		entry         = '0;
		entry.str_end = req.in_end;
		unique case (b)
			CH_AMP: begin
				entry.chars = {8'd0, CH_SEMI, CH_P, CH_M, CH_A, CH_AMP};
				entry.len   = RunW'(5);
			end
			CH_LT: begin
				entry.chars = {16'd0, CH_SEMI, CH_T, CH_L, CH_AMP};
				entry.len   = RunW'(4);
			end
			CH_GT: begin
				entry.chars = {16'd0, CH_SEMI, CH_T, CH_G, CH_AMP};
				entry.len   = RunW'(4);
			end
			CH_SPACE: begin
				entry.chars = {CH_SEMI, CH_P, CH_S, CH_B, CH_N, CH_AMP};
				entry.len   = RunW'(6);
			end
			default: begin
				if (num2) begin
					entry.chars = {8'd0, CH_SEMI, dig[7:0], dig[15:8], CH_HASH, CH_AMP};
					entry.len   = RunW'(5);
				end else if (num3) begin
					entry.chars = {CH_SEMI, dig[7:0], dig[15:8], dig[23:16], CH_HASH, CH_AMP};
					entry.len   = RunW'(6);
				end else begin
					entry.chars = {40'd0, b};
					entry.len   = RunW'(1);
				end
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hw/rtl/hee_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hee_queue
// Small FIFO of run entries between the classifier and the byte sender.
// ----------------------------------------------------------------------------
module hee_queue
	import hee_pkg::*;
#(
	parameter int DEPTH = QueueDepth
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire hee_entry_t wdata,
	input  wire logic       pop,
	output hee_entry_t      head,
	output hee_qstat_t      stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hee_entry_t      mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/hee_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hee_back
// Walks the head entry one byte per cycle into the output register while the output slot is free or being drained.
// ----------------------------------------------------------------------------
module hee_back
	import hee_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire hee_entry_t head,
	input  wire hee_qstat_t stat,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output hee_out_t        out_data
);

	logic [RunW-1:0] idx_q;
	logic            out_valid_q;
	hee_out_t        out_q;
	logic            load;
	logic            at_last;

	// queue holds an entry and the output slot is free, or is being drained this cycle
	assign load    = !stat.empty && (!out_valid_q || out_ready);
	assign at_last = (idx_q == head.len - 1'b1);
	assign pop     = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_last ? '0 : idx_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte    <= head.chars[idx_q];
			out_q.run_last    <= at_last;
			out_q.string_last <= at_last && head.str_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// File: hw/rtl/html_entity_escaper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// html_entity_escaper
// Escapes a byte stream into HTML-safe text, a run of output bytes per input byte.
// ----------------------------------------------------------------------------
// Each input byte becomes a run of one to six output bytes; run_last marks the
// end of a run and string_last the end of the run for a byte sent with in_end.
// The input side classifies a byte in the cycle it is taken and drops it into
// a four-entry queue, so input is taken every cycle while the queue has room.
// The output side sends one byte per cycle from the queue head unless out_ready
// holds it; a run is one byte for a plain byte and six bytes for a space or
// a three-digit entity. cfg_wdata sets whether bytes 128-255 are
// escaped (1) or passed raw (0); write it only while the block is idle.
module html_entity_escaper
	import hee_pkg::*;
#(
	parameter int QDEPTH = QueueDepth
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire hee_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output hee_out_t      out_data
);

	hee_entry_t new_entry;
	hee_entry_t head;
	hee_qstat_t qstat;
	logic       pop;

	hee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (in_data),
		.entry     (new_entry)
	);

	hee_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_valid),
		.wdata  (new_entry),
		.pop    (pop),
		.head   (head),
		.stat   (qstat)
	);

	hee_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign in_ready = !qstat.full;

	a_strlast_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.string_last |-> out_data.run_last)
		else $error("string_last without run_last");

	// the rest of a run is still at the queue head, so it follows at once
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.run_last |=> out_valid)
		else $error("gap inside an escape run");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_empty_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.empty && qstat.full))
		else $error("queue both empty and full");

endmodule
`default_nettype wire
